FILE: design/aarc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and arithmetic helpers for the autoalign retry controller.
// No dependencies; imported by every module of the block.
package aarc_pkg;

    localparam logic [7:0] PARABOLA_HOLDOFF  = 8'd5;
    localparam logic [7:0] BEACON_HOLDOFF    = 8'd2;
    localparam logic [7:0] TELESCOPE_HOLDOFF = 8'd5;

    localparam logic [15:0] PARABOLA_GAIN_RST  = 16'd40000;
    localparam logic [15:0] PARABOLA_STEP_RST  = 16'd2000;
    localparam logic [15:0] TELESCOPE_GAIN_RST = 16'd0;
    localparam logic [15:0] TELESCOPE_STEP_RST = 16'd0;
    localparam logic [15:0] TILT_GAIN_RST      = 16'd2000;
    localparam logic [15:0] TILT_STEP_RST      = 16'd50;
    localparam logic [22:0] FOCUS_LIMIT_RST    = 23'd52429;
    localparam logic [22:0] TILT_LIMIT_RST     = 23'd10486;

    localparam logic [2:0] CFG_PARABOLA_GAIN  = 3'd0;
    localparam logic [2:0] CFG_PARABOLA_STEP  = 3'd1;
    localparam logic [2:0] CFG_TELESCOPE_GAIN = 3'd2;
    localparam logic [2:0] CFG_TELESCOPE_STEP = 3'd3;
    localparam logic [2:0] CFG_TILT_GAIN      = 3'd4;
    localparam logic [2:0] CFG_TILT_STEP      = 3'd5;
    localparam logic [2:0] CFG_FOCUS_LIMIT    = 3'd6;
    localparam logic [2:0] CFG_TILT_LIMIT     = 3'd7;

    localparam logic [1:0] MODE_PARABOLA  = 2'd0;
    localparam logic [1:0] MODE_BEACON    = 2'd1;
    localparam logic [1:0] MODE_TELESCOPE = 2'd2;

    localparam logic [1:0] AXIS_FOCUS    = 2'd0;
    localparam logic [1:0] AXIS_BEACON_X = 2'd1;
    localparam logic [1:0] AXIS_BEACON_Y = 2'd2;

    typedef enum logic [2:0] {
        OP_TICK            = 3'd0,
        OP_START_PARABOLA  = 3'd1,
        OP_START_BEACON    = 3'd2,
        OP_START_TELESCOPE = 3'd3,
        OP_STOP            = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_STARTED  = 3'd1,
        EV_REJECTED = 3'd2,
        EV_STOPPED  = 3'd3,
        EV_MOVED    = 3'd4,
        EV_AXIS_OK  = 3'd5,
        EV_COMPLETE = 3'd6,
        EV_FAILED   = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        ACT_IDLE      = 2'd0,
        ACT_PARABOLA  = 2'd1,
        ACT_BEACON    = 2'd2,
        ACT_TELESCOPE = 2'd3
    } act_t;

    typedef struct packed {
        logic [15:0] parabola_gain;
        logic [15:0] parabola_step;
        logic [15:0] telescope_gain;
        logic [15:0] telescope_step;
        logic [15:0] tilt_gain;
        logic [15:0] tilt_step;
        logic [22:0] focus_limit;
        logic [22:0] tilt_limit;
    } cfg_t;

    typedef struct packed {
        act_t        active_mode;
        logic [7:0]  tries_count;
        logic [7:0]  holdoff_parabola;
        logic [7:0]  holdoff_beacon;
        logic [7:0]  holdoff_telescope;
    } ctrl_state_t;

    typedef struct packed {
        event_t             event_res;
        logic [1:0]         mode;
        logic [1:0]         axis;
        logic signed [20:0] move_amount;
        logic [7:0]         tries_left;
    } result_t;

    // Magnitude of a 24-bit two's complement value, 0 to 2^23.
    function automatic logic [23:0] mag24(input logic [23:0] v);
        logic [23:0] m;
        m = v[23] ? 24'(~v + 24'd1) : v;
        return m;
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        logic [7:0] r;
        r = (v == 8'hFF) ? v : 8'(v + 8'd1);
        return r;
    endfunction

    function automatic logic [1:0] mode_of(input act_t a);
        logic [1:0] r;
        case (a)
            ACT_PARABOLA:  r = MODE_PARABOLA;
            ACT_BEACON:    r = MODE_BEACON;
            ACT_TELESCOPE: r = MODE_TELESCOPE;
            default:       r = MODE_PARABOLA;
        endcase
        return r;
    endfunction

endpackage

FILE: design/autoalign_retry_controller_core.sv
`timescale 1ns / 1ps
// A result passes through the input register and then the result register.
// One request per cycle while the output is not stalled; a single step pass with one 16x24 multiplier per request.
// Reset (rst_n, asynchronous, active low): idle, try count zero, holdoff counters at their
// mode holdoff, configuration at its default values, both register stages empty.
// Depends on aarc_pkg, aarc_cfg and aarc_step.
module autoalign_retry_controller_core
    import aarc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_addr,
    input  logic [22:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // tries[7:0], focus_error[31:8], xtilt_error[55:32],
                                   // ytilt_error[79:56]
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // mode[1:0], axis[3:2], move_amount[24:4],
                                   // tries_left[32:25], zero[39:33]
    output logic [2:0]  m_tuser    // event_res[2:0]
);

    cfg_t        cfg;
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    result_t     step_res;
    result_t     res_reg;
    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic [7:0]  tries_reg;
    logic [23:0] focus_reg;
    logic [23:0] xtilt_reg;
    logic [23:0] ytilt_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        fire;

    aarc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    aarc_step u_step (
        .op          (op_t'(op_reg)),
        .tries       (tries_reg),
        .focus_error (focus_reg),
        .xtilt_error (xtilt_reg),
        .ytilt_error (ytilt_reg),
        .cfg         (cfg),
        .st          (state_reg),
        .st_next     (state_next),
        .res         (step_res)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg    <= s_tuser;
            tries_reg <= s_tdata[7:0];
            focus_reg <= s_tdata[31:8];
            xtilt_reg <= s_tdata[55:32];
            ytilt_reg <= s_tdata[79:56];
        end
    end

    // Controller state: advance once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.active_mode       <= ACT_IDLE;
            state_reg.tries_count       <= 8'd0;
            state_reg.holdoff_parabola  <= PARABOLA_HOLDOFF;
            state_reg.holdoff_beacon    <= BEACON_HOLDOFF;
            state_reg.holdoff_telescope <= TELESCOPE_HOLDOFF;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.event_res;
    assign m_tdata  = {7'd0, res_reg.tries_left, res_reg.move_amount, res_reg.axis,
                       res_reg.mode};

endmodule

FILE: design/aarc_cfg.sv
`timescale 1ns / 1ps
// Configuration register bank of the autoalign retry controller.
// Depends on aarc_pkg for the register indexes, reset values and cfg_t.
module aarc_cfg
    import aarc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_addr,
    input  logic [22:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            case (cfg_addr)
                CFG_PARABOLA_GAIN:  cfg_next.parabola_gain  = cfg_wdata[15:0];
                CFG_PARABOLA_STEP:  cfg_next.parabola_step  = cfg_wdata[15:0];
                CFG_TELESCOPE_GAIN: cfg_next.telescope_gain = cfg_wdata[15:0];
                CFG_TELESCOPE_STEP: cfg_next.telescope_step = cfg_wdata[15:0];
                CFG_TILT_GAIN:      cfg_next.tilt_gain      = cfg_wdata[15:0];
                CFG_TILT_STEP:      cfg_next.tilt_step      = cfg_wdata[15:0];
                CFG_FOCUS_LIMIT:    cfg_next.focus_limit    = cfg_wdata;
                CFG_TILT_LIMIT:     cfg_next.tilt_limit     = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.parabola_gain  <= PARABOLA_GAIN_RST;
            cfg_reg.parabola_step  <= PARABOLA_STEP_RST;
            cfg_reg.telescope_gain <= TELESCOPE_GAIN_RST;
            cfg_reg.telescope_step <= TELESCOPE_STEP_RST;
            cfg_reg.tilt_gain      <= TILT_GAIN_RST;
            cfg_reg.tilt_step      <= TILT_STEP_RST;
            cfg_reg.focus_limit    <= FOCUS_LIMIT_RST;
            cfg_reg.tilt_limit     <= TILT_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/aarc_step.sv
`timescale 1ns / 1ps
// Single-pass decision logic: command handling, holdoff, completion and move.
// Depends on aarc_pkg; purely combinational, state is held by the top level.
module aarc_step
    import aarc_pkg::*;
(
    input  op_t                op,
    input  logic [7:0]         tries,
    input  logic [23:0]        focus_error,
    input  logic [23:0]        xtilt_error,
    input  logic [23:0]        ytilt_error,
    input  cfg_t               cfg,
    input  ctrl_state_t        st,
    output ctrl_state_t        st_next,
    output result_t            res
);

    logic [23:0] fmag;
    logic [23:0] xmag;
    logic [23:0] ymag;
    logic [23:0] focus_lim;
    logic [23:0] tilt_lim;
    logic [7:0]  h_para;
    logic [7:0]  h_beacon;
    logic [7:0]  h_tele;
    logic        is_beacon;
    logic        use_x;
    logic [15:0] gain_sel;
    logic [15:0] step_sel;
    logic [23:0] mag_sel;
    logic        neg_sel;
    logic [39:0] product;
    logic [20:0] move_mag;
    logic [20:0] move_val;
    logic        acting;
    logic        done;
    act_t        req_act;
    logic [1:0]  req_mode;

    assign fmag      = mag24(focus_error);
    assign xmag      = mag24(xtilt_error);
    assign ymag      = mag24(ytilt_error);
    assign focus_lim = {1'b0, cfg.focus_limit};
    assign tilt_lim  = {1'b0, cfg.tilt_limit};

    assign h_para   = sat_inc(st.holdoff_parabola);
    assign h_beacon = sat_inc(st.holdoff_beacon);
    assign h_tele   = sat_inc(st.holdoff_telescope);

    assign is_beacon = (st.active_mode == ACT_BEACON);
    // X on an odd count after decrement
    assign use_x     = ~st.tries_count[0];

    always_comb
    begin
        case (st.active_mode)
            ACT_PARABOLA:
            begin
                gain_sel = cfg.parabola_gain;
                step_sel = cfg.parabola_step;
            end
            ACT_TELESCOPE:
            begin
                gain_sel = cfg.telescope_gain;
                step_sel = cfg.telescope_step;
            end
            default:
            begin
                gain_sel = cfg.tilt_gain;
                step_sel = cfg.tilt_step;
            end
        endcase
    end

    always_comb
    begin
        if (!is_beacon)
        begin
            mag_sel = fmag;
            neg_sel = focus_error[23];
        end
        else if (use_x)
        begin
            mag_sel = xmag;
            neg_sel = xtilt_error[23];
        end
        else
        begin
            // Y moves against the tilt sign
            mag_sel = ymag;
            neg_sel = !ytilt_error[23] && (ymag != 24'd0);
        end
    end

    assign product  = 40'(gain_sel) * 40'(mag_sel);
    assign move_mag = 21'(product[39:20]) + 21'(step_sel);
    assign move_val = neg_sel ? 21'(~move_mag + 21'd1) : move_mag;

    always_comb
    begin
        case (st.active_mode)
            ACT_PARABOLA:  acting = (h_para >= PARABOLA_HOLDOFF);
            ACT_BEACON:    acting = (h_beacon >= BEACON_HOLDOFF);
            ACT_TELESCOPE: acting = (h_tele >= TELESCOPE_HOLDOFF);
            default:       acting = 1'b0;
        endcase
    end

    assign done = is_beacon ? ((xmag < tilt_lim) && (ymag < tilt_lim))
                            : (fmag < focus_lim);

    always_comb
    begin
        case (op)
            OP_START_PARABOLA:
            begin
                req_act  = ACT_PARABOLA;
                req_mode = MODE_PARABOLA;
            end
            OP_START_BEACON:
            begin
                req_act  = ACT_BEACON;
                req_mode = MODE_BEACON;
            end
            OP_START_TELESCOPE:
            begin
                req_act  = ACT_TELESCOPE;
                req_mode = MODE_TELESCOPE;
            end
            default:
            begin
                req_act  = ACT_IDLE;
                req_mode = MODE_PARABOLA;
            end
        endcase
    end

    always_comb
    begin
        st_next         = st;
        res.event_res   = EV_NONE;
        res.mode        = MODE_PARABOLA;
        res.axis        = AXIS_FOCUS;
        res.move_amount = '0;
        case (op)
            OP_START_PARABOLA, OP_START_BEACON, OP_START_TELESCOPE:
            begin
                res.mode = req_mode;
                if (st.active_mode != ACT_IDLE && st.active_mode != req_act)
                begin
                    res.event_res = EV_REJECTED;
                end
                else
                begin
                    st_next.tries_count = tries;
                    st_next.active_mode = req_act;
                    res.event_res       = EV_STARTED;
                end
            end
            OP_STOP:
            begin
                st_next.active_mode = ACT_IDLE;
                st_next.tries_count = 8'd0;
                res.event_res       = EV_STOPPED;
            end
            OP_TICK:
            begin
                st_next.holdoff_parabola  = h_para;
                st_next.holdoff_beacon    = h_beacon;
                st_next.holdoff_telescope = h_tele;
                if (acting)
                begin
                    case (st.active_mode)
                        ACT_PARABOLA: st_next.holdoff_parabola  = 8'd0;
                        ACT_BEACON:   st_next.holdoff_beacon    = 8'd0;
                        default:      st_next.holdoff_telescope = 8'd0;
                    endcase
                    res.mode = mode_of(st.active_mode);
                    if (done)
                    begin
                        st_next.active_mode = ACT_IDLE;
                        st_next.tries_count = 8'd0;
                        res.event_res       = EV_COMPLETE;
                    end
                    else if (st.tries_count == 8'd0)
                    begin
                        st_next.active_mode = ACT_IDLE;
                        res.event_res       = EV_FAILED;
                    end
                    else
                    begin
                        st_next.tries_count = 8'(st.tries_count - 8'd1);
                        if (!is_beacon)
                        begin
                            res.event_res   = EV_MOVED;
                            res.move_amount = move_val;
                        end
                        else
                        begin
                            res.axis = use_x ? AXIS_BEACON_X : AXIS_BEACON_Y;
                            if (mag_sel > tilt_lim)
                            begin
                                res.event_res   = EV_MOVED;
                                res.move_amount = move_val;
                            end
                            else
                            begin
                                res.event_res = EV_AXIS_OK;
                            end
                        end
                    end
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
        res.tries_left = st_next.tries_count;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for autoalign_retry_controller_core: drives start, stop, tick and spare-code
// requests with random idling on both streams and predicts every event in a small class.
// Depends on aarc_pkg and the core RTL.
module testbench;
    import aarc_pkg::*;

    localparam int          CYCLE_LIMIT      = 500000;
    localparam int          SETTLE_CYCLES    = 4;
    localparam int          SQUEEZE_CYCLES   = 300;
    localparam int          RANDOM_PER_PHASE = 115;
    localparam int          LAST_PHASE       = 5;
    localparam int          REPORT_LIMIT     = 40;
    localparam logic [2:0]  OP_SPARE_FIRST   = 3'd5;
    localparam logic [2:0]  OP_SPARE_LAST    = 3'd7;

    class align_event_board;
        logic [15:0] par_gain, par_step, tel_gain, tel_step, bcn_gain, bcn_step;
        logic [22:0] focus_lim, tilt_lim;
        act_t        running;
        logic [7:0]  tries;
        logic [7:0]  since_act [3];
        result_t     awaited_events [$];
        int          mismatches;

        function new();
            par_gain  = PARABOLA_GAIN_RST;
            par_step  = PARABOLA_STEP_RST;
            tel_gain  = TELESCOPE_GAIN_RST;
            tel_step  = TELESCOPE_STEP_RST;
            bcn_gain  = TILT_GAIN_RST;
            bcn_step  = TILT_STEP_RST;
            focus_lim = FOCUS_LIMIT_RST;
            tilt_lim  = TILT_LIMIT_RST;
            running   = ACT_IDLE;
            tries     = 8'd0;
            since_act[MODE_PARABOLA]  = PARABOLA_HOLDOFF;
            since_act[MODE_BEACON]    = BEACON_HOLDOFF;
            since_act[MODE_TELESCOPE] = TELESCOPE_HOLDOFF;
            mismatches = 0;
        endfunction

        function void write_register(logic [2:0] idx, logic [22:0] val);
            case (idx)
                CFG_PARABOLA_GAIN:  par_gain  = val[15:0];
                CFG_PARABOLA_STEP:  par_step  = val[15:0];
                CFG_TELESCOPE_GAIN: tel_gain  = val[15:0];
                CFG_TELESCOPE_STEP: tel_step  = val[15:0];
                CFG_TILT_GAIN:      bcn_gain  = val[15:0];
                CFG_TILT_STEP:      bcn_step  = val[15:0];
                CFG_FOCUS_LIMIT:    focus_lim = val;
                default:            tilt_lim  = val;
            endcase
        endfunction

        function logic [7:0] holdoff_of(logic [1:0] m);
            case (m)
                MODE_PARABOLA: return PARABOLA_HOLDOFF;
                MODE_BEACON:   return BEACON_HOLDOFF;
                default:       return TELESCOPE_HOLDOFF;
            endcase
        endfunction

        function logic [23:0] magnitude(logic [23:0] v);
            return v[23] ? 24'(24'd0 - v) : v;
        endfunction

        function logic [20:0] move_of(logic [15:0] gain, logic [23:0] mag, logic [15:0] step,
                                      bit negate);
            logic [39:0] prod;
            logic [20:0] amount;
            prod   = gain * mag;
            amount = 21'(prod >> 20) + 21'(step);
            return negate ? 21'(21'd0 - amount) : amount;
        endfunction

        function int pending();
            return awaited_events.size();
        endfunction

        function void note_request(logic [2:0] op, logic [7:0] t, logic [23:0] f,
                                   logic [23:0] x, logic [23:0] y);
            result_t     r;
            act_t        wanted;
            logic [1:0]  m;
            logic [23:0] fm, xm, ym;
            bit          settled;
            r = '0;
            r.event_res = EV_NONE;
            if (op >= OP_START_PARABOLA && op <= OP_START_TELESCOPE) begin
                r.mode = 2'(op - OP_START_PARABOLA);
                wanted = act_t'(r.mode + ACT_PARABOLA);
                if (running != ACT_IDLE && running != wanted)
                    r.event_res = EV_REJECTED;
                else begin
                    tries       = t;
                    running     = wanted;
                    r.event_res = EV_STARTED;
                end
            end else if (op == OP_STOP) begin
                running     = ACT_IDLE;
                tries       = 8'd0;
                r.event_res = EV_STOPPED;
            end else if (op == OP_TICK) begin
                for (int i = 0; i < 3; i++)
                    if (since_act[i] != 8'hFF)
                        since_act[i]++;
                if (running != ACT_IDLE) begin
                    m = 2'(running - ACT_PARABOLA);
                    if (since_act[m] >= holdoff_of(m)) begin
                        since_act[m] = 8'd0;
                        fm = magnitude(f);
                        xm = magnitude(x);
                        ym = magnitude(y);
                        r.mode = m;
                        if (m == MODE_BEACON)
                            settled = (xm < tilt_lim) && (ym < tilt_lim);
                        else
                            settled = fm < focus_lim;
                        if (settled) begin
                            running     = ACT_IDLE;
                            tries       = 8'd0;
                            r.event_res = EV_COMPLETE;
                        end else if (tries == 8'd0) begin
                            running     = ACT_IDLE;
                            r.event_res = EV_FAILED;
                        end else begin
                            tries--;
                            r.event_res = EV_MOVED;
                            if (m == MODE_PARABOLA)
                                r.move_amount = move_of(par_gain, fm, par_step, f[23]);
                            else if (m == MODE_TELESCOPE)
                                r.move_amount = move_of(tel_gain, fm, tel_step, f[23]);
                            else if (tries[0]) begin
                                r.axis = AXIS_BEACON_X;
                                if (xm > tilt_lim)
                                    r.move_amount = move_of(bcn_gain, xm, bcn_step, x[23]);
                                else
                                    r.event_res = EV_AXIS_OK;
                            end else begin
                                // Y flat moves against the sign of the tilt
                                r.axis = AXIS_BEACON_Y;
                                if (ym > tilt_lim)
                                    r.move_amount = move_of(bcn_gain, ym, bcn_step,
                                                            !y[23] && ym != 24'd0);
                                else
                                    r.event_res = EV_AXIS_OK;
                            end
                        end
                    end
                end
            end
            r.tries_left = tries;
            awaited_events.push_back(r);
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [2:0] ev, logic [39:0] data);
            result_t w;
            if (awaited_events.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: event expected none, got %0d", $time, ev);
                return;
            end
            w = awaited_events.pop_front();
            check_field("event_res", w.event_res, ev);
            check_field("mode", w.mode, data[1:0]);
            check_field("axis", w.axis, data[3:2]);
            check_field("move_amount", w.move_amount, $signed(data[24:4]));
            check_field("tries_left", w.tries_left, data[32:25]);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [2:0]  cfg_addr = CFG_PARABOLA_GAIN;
    logic [22:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;   // tries[7:0], focus_error[31:8], xtilt_error[55:32],
                                 // ytilt_error[79:56]
    logic [2:0]  s_tuser = OP_TICK;   // op[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;   // mode[1:0], axis[3:2], move_amount[24:4], tries_left[32:25]
    logic [2:0]  m_tuser;   // event_res[2:0]

    align_event_board board;
    logic [22:0]      cfg_vals [8];
    bit               calm;
    bit               squeeze_req;
    int               sent;
    int               useful;
    int               cycle_count;

    autoalign_retry_controller_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [23:0] pick_err(input logic [22:0] lim);
        logic [23:0] v;
        case ($urandom_range(0, 9))
            0:       v = 24'h800000;
            1:       v = 24'h7FFFFF;
            2:       v = 24'h000000;
            3:       v = {1'b0, lim};
            4:       v = {1'b0, lim} - 24'd1;
            5:       v = {1'b0, lim} + 24'd1;
            6, 7:    v = 24'($urandom_range(0, 2 * lim + 16));
            default: v = 24'($urandom);
        endcase
        if ($urandom_range(0, 1) == 1)
            v = 24'(24'd0 - v);
        return v;
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [7:0] t,
                                input logic [23:0] f, input logic [23:0] x,
                                input logic [23:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {y, x, f, t};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_request(op, t, f, x, y);
        if (op <= OP_STOP)
            useful++;
        sent++;
        if (sent % 40 == 0)
            calm = ($urandom_range(0, 3) == 0);
    endtask

    // drop valid and wait for every event to come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_result(m_tuser, m_tdata);
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                hold_left   = SQUEEZE_CYCLES;
            end
            if (hold_left > 0)
                hold_left--;
            else if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap();
            m_tready <= (hold_left == 0 && stall_left == 0);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [2:0] op;
        logic [7:0] t;
        int         start_count;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stop and tick while idle, spare codes, rejection and restart
        send_request(OP_STOP, 8'd0, 24'd0, 24'd0, 24'd0);
        send_request(OP_TICK, 8'd0, 24'd0, 24'd0, 24'd0);
        for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
            send_request(3'(c), 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_request(OP_START_PARABOLA, 8'hFF, 24'd0, 24'd0, 24'd0);
        send_request(OP_START_BEACON, 8'd7, 24'd0, 24'd0, 24'd0);
        send_request(OP_START_TELESCOPE, 8'd7, 24'd0, 24'd0, 24'd0);
        send_request(OP_START_PARABOLA, 8'd2, 24'd0, 24'd0, 24'd0);
        // parabola: two moves at full scale, then run out of tries on the limit itself
        send_request(OP_TICK, 8'd0, 24'h7FFFFF, 24'd0, 24'd0);
        repeat (4) send_request(OP_TICK, 8'd0, 24'd0, 24'd0, 24'd0);
        send_request(OP_TICK, 8'd0, 24'h800000, 24'd0, 24'd0);
        repeat (4) send_request(OP_TICK, 8'd0, 24'd0, 24'd0, 24'd0);
        send_request(OP_TICK, 8'd0, {1'b0, board.focus_lim}, 24'd0, 24'd0);
        // beacon: x exactly on the limit, y moved, then both inside
        send_request(OP_START_BEACON, 8'd2, 24'd0, 24'd0, 24'd0);
        send_request(OP_TICK, 8'd0, 24'd0, {1'b0, board.tilt_lim}, 24'h800000);
        send_request(OP_TICK, 8'd0, 24'd0, 24'd0, 24'd0);
        send_request(OP_TICK, 8'd0, 24'd0, 24'd0, 24'h7FFFFF);
        send_request(OP_TICK, 8'd0, 24'd0, 24'd0, 24'd0);
        send_request(OP_TICK, 8'd0, 24'd0, {1'b0, board.tilt_lim} - 24'd1,
                     24'(24'd0 - ({1'b0, board.tilt_lim} - 24'd1)));

        for (int phase = 1; phase <= LAST_PHASE; phase++)
        begin
            settle();
            case (phase)
                1:
                begin
                    foreach (cfg_vals[i])
                        cfg_vals[i] = 23'h7FFFFF;
                end
                2:
                begin
                    foreach (cfg_vals[i])
                        cfg_vals[i] = 23'h000000;
                end
                3:
                begin
                    foreach (cfg_vals[i])
                        cfg_vals[i] = 23'h7FFFFF;
                    cfg_vals[CFG_FOCUS_LIMIT] = 23'h000000;
                    cfg_vals[CFG_TILT_LIMIT]  = 23'h000000;
                end
                default:
                begin
                    foreach (cfg_vals[i])
                        cfg_vals[i] = 23'($urandom);
                    cfg_vals[CFG_FOCUS_LIMIT] = 23'($urandom_range(0, 300000));
                    cfg_vals[CFG_TILT_LIMIT]  = 23'($urandom_range(0, 100000));
                end
            endcase
            for (int i = 0; i < 8; i++)
            begin
                cfg_wen   <= 1'b1;
                cfg_addr  <= 3'(i);
                cfg_wdata <= cfg_vals[i];
                board.write_register(3'(i), cfg_vals[i]);
                @(posedge clk);
            end
            cfg_wen <= 1'b0;
            if (phase == 2)
                squeeze_req = 1'b1;

            // mostly well-formed runs: a start, then ticks with some noise mixed in
            start_count = useful;
            while (useful - start_count < RANDOM_PER_PHASE)
            begin
                op = 3'($urandom_range(OP_START_PARABOLA, OP_START_TELESCOPE));
                t  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
                send_request(op, t, 24'($urandom), 24'($urandom), 24'($urandom));
                repeat ($urandom_range(4, 30))
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_request(3'($urandom), 8'($urandom), 24'($urandom),
                                     24'($urandom), 24'($urandom));
                    else
                        send_request(OP_TICK, 8'($urandom), pick_err(board.focus_lim),
                                     pick_err(board.tilt_lim), pick_err(board.tilt_lim));
                end
            end
        end

        settle();
        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
design/aarc_pkg.sv
design/aarc_cfg.sv
design/aarc_step.sv
design/autoalign_retry_controller_core.sv
tb/testbench.sv
